// ===== src/cst_pkg.sv =====
// Shared types and constants for the chunked slot table.
// Used by chunked_slot_table_core and cst_out_reg; depends on nothing else.
`timescale 1ns / 1ps

package cst_pkg;

  // Fixed field widths of the streaming and configuration ports.
  localparam int CHUNK_W     = 9;
  localparam int KEY_IN_W    = 32;
  localparam int CNT_OUT_W   = 9;
  localparam int OUT_TDATA_W = 24;

  // Chunk size after reset.
  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 9'd16;

  // Request codes carried in in_tuser.
  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_DEL = 1'b1;

  // Result status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_RD,
    S_ADD_CHK,
    S_ADD_GROW,
    S_DEL_RD,
    S_DEL_CHK,
    S_CMP_RD,
    S_CMP_CHK,
    S_FR_RD,
    S_FR_CHK,
    S_MOVE_CLR,
    S_SHRINK,
    S_DONE
  } state_t;

  // One result item as handed from the sequencer to the output register.
  typedef struct packed {
    logic [CNT_OUT_W-1:0] empty_slots;
    logic [CNT_OUT_W-1:0] active_slots;
    logic                 compacted;
    logic [1:0]           status;
  } res_t;

endpackage

// ===== src/cst_out_reg.sv =====
// Output register of the chunked slot table: holds one finished result
// until the downstream side takes it. Depends on cst_pkg.
`timescale 1ns / 1ps

module cst_out_reg import cst_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load_valid,
  input  res_t                   load_res,
  output logic                   load_ready,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // Fields from bit 0 up: status[1:0], compacted[2], active_slots[11:3],
  // empty_slots[20:12], zero fill [23:21].
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  // The register can take a new result when empty or when it drains now.
  assign load_ready = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load_valid && load_ready) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      res_r <= load_res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {
    (OUT_TDATA_W - 2 * CNT_OUT_W - 3)'(0),
    res_r.empty_slots,
    res_r.active_slots,
    res_r.compacted,
    res_r.status
  };

endmodule

// ===== src/chunked_slot_table_core.sv =====
// Top level of the chunked slot table: sequencer, slot memory and counts.
// Depends on cst_pkg and cst_out_reg.
`timescale 1ns / 1ps
//
//   Channel | Ports                          | Content
//   --------+--------------------------------+----------------------------------
//   input   | in_tvalid/in_tready/in_tdata   | tuser: req_type; tdata: key
//           | in_tuser                       |
//   result  | out_tvalid/out_tready/out_tdata| status, compacted, active, empty
//   config  | cfg_we/cfg_wdata               | chunk_size, clears the table
//
// Each request is run by a sequencer over one single-port slot memory with a
// registered read, so every slot visited takes a read state and a check state.
// An add scans up from slot 0 to the lowest empty slot, or grows the table by
// one chunk when none is empty; a delete scans down from the top for the key
// and, when it compacts, moves the keys of the top chunk into the lowest holes.
// After reset and after every chunk_size write a clearing pass zeroes the
// memory; no transfer is taken meanwhile. A stalled result sits in the output
// register; the next request runs and waits only at its end.

module chunked_slot_table_core import cst_pkg::*; #(
  parameter int MAX_SLOTS = 256,
  parameter int KEY_BITS  = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // Fields from bit 0 up: key[31:0].
  input  logic [KEY_IN_W-1:0]    in_tdata,
  // Fields from bit 0 up: req_type[0].
  input  logic                   in_tuser,
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // Fields from bit 0 up: status[1:0], compacted[2], active_slots[11:3],
  // empty_slots[20:12], zero fill [23:21].
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Configuration.
  input  logic                   cfg_we,
  input  logic [CHUNK_W-1:0]     cfg_wdata
);

  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int IW = $clog2(MAX_SLOTS);
  localparam logic [CW:0]   MAX_W    = (CW + 1)'(MAX_SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_SLOTS - 1);

  // Effective chunk size: zero acts as one, large values stop at MAX_SLOTS.
  function automatic logic [CW-1:0] eff_of(input logic [CHUNK_W-1:0] v);
    logic [CW-1:0] r;
    if (v == '0) begin
      r = CW'(1);
    end else if (32'(v) > MAX_SLOTS) begin
      r = CW'(MAX_SLOTS);
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  // Registers.
  state_t              state_r, state_nxt;
  logic [CHUNK_W-1:0]  chunk_r;
  logic [CW-1:0]       active_r, active_nxt;
  logic [CW-1:0]       empty_r, empty_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       fr_r, fr_nxt;
  logic [CW-1:0]       low_r, low_nxt;
  logic [IW-1:0]       clr_idx_r, clr_idx_nxt;
  logic                op_r, op_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [KEY_BITS-1:0] val_r, val_nxt;
  logic [1:0]          status_r, status_nxt;
  logic                compacted_r, compacted_nxt;
  logic [KEY_BITS-1:0] rd_data_r;

  // Slot memory port.
  logic [KEY_BITS-1:0] mem [MAX_SLOTS];
  logic                mem_we;
  logic                mem_re;
  logic [IW-1:0]       mem_addr;
  logic [KEY_BITS-1:0] mem_wdata;

  // Shared predicates.
  logic [CW-1:0]       eff_chunk;
  logic [63:0]         key_ext;
  logic [KEY_BITS-1:0] key_in;
  logic                accept;
  logic                key_in_zero;
  logic                has_empty;
  logic                grow_ok;
  logic                rd_zero;
  logic                rd_hit;
  logic [CW-1:0]       idx_m1;
  logic                add_last;
  logic                shrink_due;
  logic                cmp_done;
  logic                fr_over;
  logic                res_load;
  logic                res_ready;
  res_t                res;
  logic [31:0]         active_ext;
  logic [31:0]         empty_ext;

  assign eff_chunk   = eff_of(chunk_r);
  assign key_ext     = {32'b0, in_tdata};
  assign key_in      = key_ext[KEY_BITS-1:0];
  assign in_tready   = (state_r == S_IDLE);
  assign accept      = in_tvalid && in_tready;
  assign key_in_zero = (key_in == '0);
  assign has_empty   = (empty_r != '0);
  assign grow_ok     = (({1'b0, active_r} + {1'b0, eff_chunk}) <= MAX_W);
  assign rd_zero     = (rd_data_r == '0);
  assign rd_hit      = (rd_data_r == key_r);
  assign idx_m1      = idx_r - CW'(1);
  assign add_last    = (({1'b0, idx_r} + (CW + 1)'(1)) >= {1'b0, active_r});
  assign shrink_due  = (({1'b0, empty_r} + (CW + 1)'(1)) >= {eff_chunk, 1'b0})
                       && (active_r >= eff_chunk);
  assign cmp_done    = (idx_r == low_r);
  assign fr_over     = (fr_r >= low_r);

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_idx_r == LAST_IDX) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_tuser == REQ_ADD) begin
            if (key_in_zero)    state_nxt = S_DONE;
            else if (has_empty) state_nxt = S_ADD_RD;
            else if (grow_ok)   state_nxt = S_ADD_GROW;
            else                state_nxt = S_DONE;
          end else begin
            if (key_in_zero || active_r == '0) state_nxt = S_DONE;
            else                               state_nxt = S_DEL_RD;
          end
        end
      end
      S_ADD_RD:   state_nxt = S_ADD_CHK;
      S_ADD_CHK: begin
        if (rd_zero || add_last) state_nxt = S_DONE;
        else                     state_nxt = S_ADD_RD;
      end
      S_ADD_GROW: state_nxt = S_DONE;
      S_DEL_RD:   state_nxt = S_DEL_CHK;
      S_DEL_CHK: begin
        if (rd_hit) begin
          state_nxt = shrink_due ? S_CMP_RD : S_DONE;
        end else if (idx_m1 == '0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DEL_RD;
        end
      end
      S_CMP_RD:   state_nxt = cmp_done ? S_SHRINK : S_CMP_CHK;
      S_CMP_CHK:  state_nxt = rd_zero ? S_CMP_RD : S_FR_RD;
      S_FR_RD:    state_nxt = fr_over ? S_SHRINK : S_FR_CHK;
      S_FR_CHK:   state_nxt = rd_zero ? S_MOVE_CLR : S_FR_RD;
      S_MOVE_CLR: state_nxt = S_CMP_RD;
      S_SHRINK:   state_nxt = S_DONE;
      S_DONE: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_CLEAR;
    endcase
  end

  // Memory control and datapath updates for each state.
  always_comb begin
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = idx_r[IW-1:0];
    mem_wdata     = '0;
    active_nxt    = active_r;
    empty_nxt     = empty_r;
    idx_nxt       = idx_r;
    fr_nxt        = fr_r;
    low_nxt       = low_r;
    clr_idx_nxt   = clr_idx_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    status_nxt    = status_r;
    compacted_nxt = compacted_r;
    res_load      = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_addr    = clr_idx_r;
        clr_idx_nxt = clr_idx_r + IW'(1);
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt        = in_tuser;
          key_nxt       = key_in;
          compacted_nxt = 1'b0;
          status_nxt    = STAT_OK;
          if (in_tuser == REQ_ADD) begin
            idx_nxt = '0;
            if (key_in_zero || (!has_empty && !grow_ok)) status_nxt = STAT_FULL;
          end else begin
            idx_nxt = active_r;
            if (key_in_zero || active_r == '0) status_nxt = STAT_NOT_FOUND;
          end
        end
      end
      S_ADD_RD: begin
        mem_re = 1'b1;
      end
      S_ADD_CHK: begin
        // First empty slot takes the key.
        if (rd_zero) begin
          mem_we    = 1'b1;
          mem_wdata = key_r;
          empty_nxt = empty_r - CW'(1);
        end else begin
          idx_nxt = idx_r + CW'(1);
          if (add_last) status_nxt = STAT_FULL;
        end
      end
      S_ADD_GROW: begin
        // New chunk is already zero; the key goes into its first slot.
        mem_we     = 1'b1;
        mem_addr   = active_r[IW-1:0];
        mem_wdata  = key_r;
        active_nxt = active_r + eff_chunk;
        empty_nxt  = empty_r + eff_chunk - CW'(1);
      end
      S_DEL_RD: begin
        mem_re   = 1'b1;
        mem_addr = idx_m1[IW-1:0];
      end
      S_DEL_CHK: begin
        mem_addr = idx_m1[IW-1:0];
        if (rd_hit) begin
          mem_we    = 1'b1;
          empty_nxt = empty_r + CW'(1);
          if (shrink_due) begin
            low_nxt = active_r - eff_chunk;
            idx_nxt = active_r;
            fr_nxt  = '0;
          end
        end else begin
          idx_nxt = idx_m1;
          if (idx_m1 == '0) status_nxt = STAT_NOT_FOUND;
        end
      end
      S_CMP_RD: begin
        // Read the next slot of the top chunk, top first.
        mem_addr = idx_m1[IW-1:0];
        mem_re   = !cmp_done;
      end
      S_CMP_CHK: begin
        if (rd_zero) begin
          idx_nxt = idx_m1;
        end else begin
          val_nxt = rd_data_r;
        end
      end
      S_FR_RD: begin
        mem_addr = fr_r[IW-1:0];
        mem_re   = !fr_over;
      end
      S_FR_CHK: begin
        mem_addr = fr_r[IW-1:0];
        if (rd_zero) begin
          mem_we    = 1'b1;
          mem_wdata = val_r;
        end else begin
          fr_nxt = fr_r + CW'(1);
        end
      end
      S_MOVE_CLR: begin
        mem_we   = 1'b1;
        mem_addr = idx_m1[IW-1:0];
        idx_nxt  = idx_m1;
      end
      S_SHRINK: begin
        active_nxt    = active_r - eff_chunk;
        empty_nxt     = empty_r - eff_chunk;
        compacted_nxt = 1'b1;
      end
      S_DONE: begin
        res_load = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Control registers; a chunk_size write restarts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      chunk_r   <= CHUNK_RESET;
      active_r  <= eff_of(CHUNK_RESET);
      empty_r   <= eff_of(CHUNK_RESET);
      clr_idx_r <= '0;
    end else if (cfg_we) begin
      state_r   <= S_CLEAR;
      chunk_r   <= cfg_wdata;
      active_r  <= eff_of(cfg_wdata);
      empty_r   <= eff_of(cfg_wdata);
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      active_r  <= active_nxt;
      empty_r   <= empty_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    fr_r        <= fr_nxt;
    low_r       <= low_nxt;
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    val_r       <= val_nxt;
    status_r    <= status_nxt;
    compacted_r <= compacted_nxt;
  end

  // Single-port slot memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  // Result assembly; the counts are final once the sequencer reaches DONE.
  assign active_ext       = 32'(active_r);
  assign empty_ext        = 32'(empty_r);
  assign res.status       = status_r;
  assign res.compacted    = compacted_r;
  assign res.active_slots = active_ext[CNT_OUT_W-1:0];
  assign res.empty_slots  = empty_ext[CNT_OUT_W-1:0];

  cst_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (res_load),
    .load_res   (res),
    .load_ready (res_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // The empty count never exceeds the active size.
  a_empty_le_active: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r <= active_r)
    else $error("empty count above active size");

  // The active size stays within the memory.
  a_active_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, active_r} <= MAX_W)
    else $error("active size beyond MAX_SLOTS");

  // A transfer starts a request, so the next cycle takes none.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !cfg_we |=> !in_tready)
    else $error("input taken while a request runs");

  // A delete only shrinks when the table holds at least one chunk.
  a_shrink_legal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHRINK |-> (active_r >= eff_chunk) && (op_r == REQ_DEL))
    else $error("shrink without a full chunk or outside a delete");

endmodule

// ===== tb/sv/tb_chunked_slot_table_core.sv =====
// Self-checking testbench for chunked_slot_table_core: a scoreboard class keeps its own
// copy of the slot table and predicts every result, plain tasks drive the streams.
// Depends on cst_pkg and the chunked_slot_table_core RTL.
`timescale 1ns / 1ps

module tb_chunked_slot_table_core;
  import cst_pkg::*;

  localparam int TABLE_SLOTS = 256;

  typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_LONG} rx_mode_t;

  // Scoreboard: mirrors the slot table and queues the expected results in order.
  class slot_table_scoreboard;
    logic [KEY_IN_W-1:0] slots [TABLE_SLOTS];
    int unsigned active_cnt;
    int unsigned empty_cnt;
    logic [CHUNK_W-1:0] chunk_reg;
    res_t expected_q[$];
    int unsigned errors, checked, adds, dels, fulls, misses;
    int unsigned compactions, grows, peak_active;

    function new();
      chunk_reg = CHUNK_RESET;
      clear_slots();
    endfunction

    // Zero is treated as one slot and anything above the table size as the
    // whole table.
    function int unsigned step_size();
      if (chunk_reg == 0) return 1;
      if (chunk_reg > TABLE_SLOTS) return TABLE_SLOTS;
      return 32'(chunk_reg);
    endfunction

    function void clear_slots();
      foreach (slots[i]) slots[i] = '0;
      active_cnt = step_size();
      empty_cnt = active_cnt;
    endfunction

    function void set_chunk(logic [CHUNK_W-1:0] value);
      chunk_reg = value;
      clear_slots();
    endfunction

    // Add into the lowest empty slot, or grow by one chunk when none is free.
    function logic [1:0] apply_add(logic [KEY_IN_W-1:0] key);
      int unsigned c, i;
      c = step_size();
      if (key == 0) return STAT_FULL;
      if (empty_cnt > 0) begin
        for (i = 0; i < active_cnt && i < TABLE_SLOTS; i++) begin
          if (slots[i] == 0) begin
            slots[i] = key;
            empty_cnt--;
            return STAT_OK;
          end
        end
        return STAT_FULL;
      end
      if (active_cnt + c > TABLE_SLOTS) return STAT_FULL;
      slots[active_cnt] = key;
      for (i = active_cnt + 1; i < active_cnt + c; i++) slots[i] = '0;
      active_cnt += c;
      empty_cnt += c - 1;
      grows++;
      return STAT_OK;
    endfunction

    // Delete the topmost match; shrink by one chunk once enough slots are empty.
    function logic [1:0] apply_delete(logic [KEY_IN_W-1:0] key, output logic shrunk);
      int unsigned c, i, low, fr;
      logic [KEY_IN_W-1:0] v;
      bit hit;
      shrunk = 1'b0;
      hit = 1'b0;
      c = step_size();
      if (key == 0) return STAT_NOT_FOUND;
      for (i = (active_cnt > TABLE_SLOTS) ? TABLE_SLOTS : active_cnt; i > 0; i--) begin
        if (slots[i-1] == key) begin
          slots[i-1] = '0;
          empty_cnt++;
          hit = 1'b1;
          break;
        end
      end
      if (!hit) return STAT_NOT_FOUND;
      if (empty_cnt / c < 2 || active_cnt < c) return STAT_OK;
      // Move the keys of the top chunk, highest first, into the lowest holes.
      low = active_cnt - c;
      fr = 0;
      for (i = active_cnt; i > low; i--) begin
        v = slots[i-1];
        if (v != 0) begin
          while (fr < low && slots[fr] != 0) fr++;
          if (fr >= low) break;
          slots[fr] = v;
          slots[i-1] = '0;
        end
      end
      active_cnt -= c;
      empty_cnt -= c;
      shrunk = 1'b1;
      return STAT_OK;
    endfunction

    // Called once per accepted request transfer.
    function void note_request(logic req, logic [KEY_IN_W-1:0] key);
      res_t r;
      logic shrunk;
      shrunk = 1'b0;
      if (req == REQ_ADD) begin
        r.status = apply_add(key);
        adds++;
        if (r.status == STAT_FULL) fulls++;
      end else begin
        r.status = apply_delete(key, shrunk);
        dels++;
        if (r.status == STAT_NOT_FOUND) misses++;
        if (shrunk) compactions++;
      end
      r.compacted = shrunk;
      r.active_slots = active_cnt[CNT_OUT_W-1:0];
      r.empty_slots = empty_cnt[CNT_OUT_W-1:0];
      if (active_cnt > peak_active) peak_active = active_cnt;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    // Called once per accepted result transfer.
    function void check_result(logic [OUT_TDATA_W-1:0] data);
      res_t got, want;
      got = data[$bits(res_t)-1:0];
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, got %h", $time, data);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("compacted", 32'(want.compacted), 32'(got.compacted));
      compare_field("active_slots", 32'(want.active_slots), 32'(got.active_slots));
      compare_field("empty_slots", 32'(want.empty_slots), 32'(got.empty_slots));
    endfunction

    // A random key that is stored right now, or zero when the table is empty.
    function logic [KEY_IN_W-1:0] pick_stored_key();
      logic [KEY_IN_W-1:0] found[$];
      for (int i = 0; i < active_cnt; i++) if (slots[i] != 0) found.push_back(slots[i]);
      if (found.size() == 0) return '0;
      return found[$urandom_range(0, found.size() - 1)];
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [KEY_IN_W-1:0]    in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CHUNK_W-1:0]     cfg_wdata = '0;

  slot_table_scoreboard sb;
  rx_mode_t rx_mode = RX_ALWAYS;
  logic [7:0] rx_tick = '0;
  int unsigned stall_left = 0;
  int burst_left = 0;
  logic [KEY_IN_W-1:0] key_pool [12];

  chunked_slot_table_core #(
    .MAX_SLOTS(TABLE_SLOTS),
    .KEY_BITS (32)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver backpressure follows the pattern of the current mode.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 8'd1;
    case (rx_mode)
      RX_ALWAYS: out_tready <= 1'b1;
      RX_COIN: out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= (rx_tick[1:0] == 2'd0);
      default: begin
        if (stall_left != 0) begin
          out_tready <= 1'b0;
          stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 9) == 0) begin
          out_tready <= 1'b0;
          stall_left <= $urandom_range(5, 40);
        end else begin
          out_tready <= 1'b1;
        end
      end
    endcase
  end

  // Every result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Present one request and hold it until the transfer happens.
  task automatic send_request(logic req, logic [KEY_IN_W-1:0] key);
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= key;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(req, key);
  endtask

  task automatic pause_sender(int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop sending until every predicted result has been seen.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  // The block is idle here, so the write clears its table and ours at the same edge.
  task automatic write_chunk_size(logic [CHUNK_W-1:0] value);
    drain_results();
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_chunk(value);
  endtask

  // Random traffic with a given add share; deletes mostly target stored keys.
  task automatic run_phase(int count, int add_pct, rx_mode_t mode, bit gaps);
    logic req;
    logic [KEY_IN_W-1:0] key;
    int roll;
    rx_mode <= mode;
    foreach (key_pool[i]) key_pool[i] = $urandom | 32'h1;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < add_pct) begin
        req = REQ_ADD;
        if (roll < 55) key = key_pool[$urandom_range(0, 11)];
        else if (roll < 99) key = $urandom;
        else key = '0;
      end else begin
        req = REQ_DEL;
        key = sb.pick_stored_key();
        if (roll >= 70 || key == 0) key = key_pool[$urandom_range(0, 11)];
        if (roll >= 90) key = $urandom;
        if (roll >= 98) key = '0;
      end
      send_request(req, key);
      if ($urandom_range(0, 39) == 0) begin
        drain_results();
      end else if (gaps) begin
        if (burst_left <= 0) begin
          pause_sender($urandom_range(1, 16));
          burst_left = $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
    end
  endtask

  initial begin
    #60_000_000;
    $display("tb_chunked_slot_table_core failed");
    $finish;
  end

  initial begin
    sb = new();
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset size: zero keys are refused, all-ones key goes in and out.
    send_request(REQ_ADD, '0);
    send_request(REQ_DEL, '0);
    send_request(REQ_ADD, 32'hFFFF_FFFF);
    send_request(REQ_DEL, 32'hFFFF_FFFF);

    // Chunks of two: growth, duplicates, top-down delete and compaction with a move.
    write_chunk_size(9'd2);
    send_request(REQ_ADD, '0);
    send_request(REQ_DEL, '0);
    send_request(REQ_DEL, 32'h1234_5678);
    send_request(REQ_ADD, 32'hFFFF_FFFF);
    send_request(REQ_ADD, 32'h0000_0001);
    send_request(REQ_ADD, 32'h8000_0000);
    send_request(REQ_ADD, 32'hFFFF_FFFF);
    send_request(REQ_ADD, 32'h0000_0005);
    send_request(REQ_DEL, 32'h0000_0001);
    send_request(REQ_DEL, 32'h8000_0000);
    send_request(REQ_DEL, 32'hFFFF_FFFF);
    send_request(REQ_DEL, 32'hFFFF_FFFF);
    send_request(REQ_DEL, 32'h0000_0005);
    send_request(REQ_DEL, 32'h0000_0005);
    send_request(REQ_ADD, 32'h0000_0007);

    // Random phases over several chunk sizes, the extremes among them.
    write_chunk_size(9'd1);
    run_phase(100, 60, RX_COIN, 1'b1);
    write_chunk_size(9'd0);
    run_phase(40, 50, RX_SPARSE, 1'b1);
    write_chunk_size(9'd3);
    run_phase(60, 75, RX_LONG, 1'b1);
    run_phase(50, 25, RX_ALWAYS, 1'b0);
    write_chunk_size(9'd7);
    run_phase(80, 55, RX_COIN, 1'b1);
    // Mostly adds until the table refuses further growth.
    write_chunk_size(9'd200);
    run_phase(250, 96, RX_ALWAYS, 1'b1);
    write_chunk_size(9'd511);
    run_phase(30, 50, RX_LONG, 1'b1);
    write_chunk_size(9'd256);
    run_phase(20, 50, RX_COIN, 1'b0);

    drain_results();
    repeat (40) @(posedge clk);
    $display("Covered %0d adds (%0d grew the table, %0d refused)",
             sb.adds, sb.grows, sb.fulls);
    $display("and %0d deletes (%0d missed, %0d compacted); %0d results checked.",
             sb.dels, sb.misses, sb.compactions, sb.checked);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_chunked_slot_table_core passed");
    end else begin
      $display("tb_chunked_slot_table_core failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/cst_pkg.sv
src/cst_out_reg.sv
src/chunked_slot_table_core.sv
tb/sv/tb_chunked_slot_table_core.sv
